/* rtl/lss_pkg.sv */
`default_nettype none

package lss_pkg;

  // register indexes on the configuration port (byte address is 4 * index)
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_PULSE_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_ON_TICKS     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_OFF_TICKS    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_PULSE_COUNT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_ON_TICKS    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_OFF_TICKS   = 3'd5;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 8;

  // reset values of the timing registers
  localparam logic [CFG_W-1:0] RST_PULSE_COUNT = 8'd200;
  localparam logic [CFG_W-1:0] RST_FIRST_ON    = 8'd10;
  localparam logic [CFG_W-1:0] RST_OFF         = 8'd10;
  localparam logic [CFG_W-1:0] RST_SECOND_ON   = 8'd20;

  typedef struct packed {
    logic [CFG_W-1:0] first_pulse_count;
    logic [CFG_W-1:0] first_on_ticks;
    logic [CFG_W-1:0] first_off_ticks;
    logic [CFG_W-1:0] second_pulse_count;
    logic [CFG_W-1:0] second_on_ticks;
    logic [CFG_W-1:0] second_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic gate_on;
    logic ramping;
  } res_t;

  typedef struct packed {
    logic ramp_active;  // sequencer is inside a soft-start
  } seq_status_t;

endpackage

`default_nettype wire

/* rtl/lss_seq.sv */
`default_nettype none

module lss_seq import lss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        step,
  input  wire logic        enable_request,
  input  wire logic        test_mode,
  output res_t             result,
  output seq_status_t      status
);

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ON  = 2'd1,
    MODE_PH1 = 2'd2,
    MODE_PH2 = 2'd3
  } mode_t;

  mode_t            mode, mode_next;
  logic [CFG_W-1:0] pulse_counter, pulse_counter_next;
  logic [CFG_W-1:0] tick_counter, tick_counter_next;
  logic             in_off_part, in_off_part_next;

  // one soft-start tick, from either the running state or a fresh start
  logic             ramp_en;
  logic             ramp_ph2;
  logic [CFG_W-1:0] ramp_pc, ramp_tc;
  logic             ramp_off;
  logic [CFG_W-1:0] dur, count, tc_inc, pc_inc;

  always_comb begin
    ramp_en   = 1'b0;
    ramp_ph2  = 1'b0;
    ramp_pc   = pulse_counter;
    ramp_tc   = tick_counter;
    ramp_off  = in_off_part;
    mode_next          = mode;
    pulse_counter_next = pulse_counter;
    tick_counter_next  = tick_counter;
    in_off_part_next   = in_off_part;
    result.gate_on = 1'b1;
    result.ramping = 1'b0;

    priority if (mode == MODE_PH1 || mode == MODE_PH2) begin
      ramp_en  = 1'b1;
      ramp_ph2 = (mode == MODE_PH2);
    end else if (test_mode) begin
      mode_next = MODE_ON;
    end else if (!enable_request) begin
      mode_next      = MODE_OFF;
      result.gate_on = 1'b0;
    end else if (mode == MODE_OFF) begin
      // fresh start, skipping phases with no pulses
      ramp_pc  = '0;
      ramp_tc  = '0;
      ramp_off = 1'b0;
      pulse_counter_next = '0;
      tick_counter_next  = '0;
      in_off_part_next   = 1'b0;
      if (cfg.first_pulse_count != '0) begin
        ramp_en = 1'b1;
      end else if (cfg.second_pulse_count != '0) begin
        ramp_en  = 1'b1;
        ramp_ph2 = 1'b1;
      end else begin
        mode_next = MODE_ON;
      end
    end else begin
      mode_next = MODE_ON;
    end

    // half-pulse duration, zero counts as one tick
    if (ramp_ph2) begin
      dur   = ramp_off ? cfg.second_off_ticks : cfg.second_on_ticks;
      count = cfg.second_pulse_count;
    end else begin
      dur   = ramp_off ? cfg.first_off_ticks : cfg.first_on_ticks;
      count = cfg.first_pulse_count;
    end
    if (dur == '0) begin
      dur = CFG_W'(1);
    end
    tc_inc = ramp_tc + CFG_W'(1);
    pc_inc = ramp_pc + CFG_W'(1);

    if (ramp_en) begin
      result.gate_on = !ramp_off;
      result.ramping = 1'b1;
      mode_next          = ramp_ph2 ? MODE_PH2 : MODE_PH1;
      pulse_counter_next = ramp_pc;
      in_off_part_next   = ramp_off;
      if (tc_inc < dur) begin
        tick_counter_next = tc_inc;
      end else begin
        tick_counter_next = '0;
        if (!ramp_off) begin
          in_off_part_next = 1'b1;
        end else begin
          in_off_part_next = 1'b0;
          if (pc_inc >= count) begin
            pulse_counter_next = '0;
            if (!ramp_ph2 && cfg.second_pulse_count != '0) begin
              mode_next = MODE_PH2;
            end else begin
              mode_next = MODE_ON;
            end
          end else begin
            pulse_counter_next = pc_inc;
          end
        end
      end
    end
  end

  assign status.ramp_active = (mode == MODE_PH1 || mode == MODE_PH2);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OFF;
      pulse_counter <= '0;
      tick_counter  <= '0;
      in_off_part   <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      pulse_counter <= pulse_counter_next;
      tick_counter  <= tick_counter_next;
      in_off_part   <= in_off_part_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/load_switch_soft_start.sv */
// load switch soft-start sequencer
//
// input channel: in_valid / in_ready with enable_request and test_mode; each
// request is one microsecond tick of the timebase. output channel: out_valid /
// out_ready with gate_on and ramping; every request gives exactly one result.
// an accepted request's result is registered in the output register or the
// skid register on a stall. throughput: one request per clock while in_ready
// is high, set by the sequencer state update (mode, pulse and tick counters).
// configuration: apb-style write/read port, registers at byte address 4*i; user
// writes only while channels are idle, unenforced; new timing applies at once.
// reset (rst, synchronous): sequencer goes to off, counters clear, timing
// registers return to 200/10/10/200/20/10, both output stages empty.
// receiver stall: the output register holds its result and a skid register
// takes one more request, so in_ready drops only when both are full; no
// result is lost or repeated.
`default_nettype none

module load_switch_soft_start import lss_pkg::*; #(
  parameter logic [CFG_W-1:0] FIRST_PULSE_RST  = RST_PULSE_COUNT,
  parameter logic [CFG_W-1:0] FIRST_ON_RST     = RST_FIRST_ON,
  parameter logic [CFG_W-1:0] FIRST_OFF_RST    = RST_OFF,
  parameter logic [CFG_W-1:0] SECOND_PULSE_RST = RST_PULSE_COUNT,
  parameter logic [CFG_W-1:0] SECOND_ON_RST    = RST_SECOND_ON,
  parameter logic [CFG_W-1:0] SECOND_OFF_RST   = RST_OFF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // tick requests
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              enable_request,
  input  wire logic              test_mode,
  // results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   gate_on,
  output logic                   ramping
);

  cfg_t             cfg;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  res_t        seq_res;
  seq_status_t seq_st;
  logic        accept;
  logic        pop;

  // output register and skid register
  res_t out_res;
  res_t skid_res;
  logic skid_valid;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register file, low byte of the write data is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_pulse_count  <= FIRST_PULSE_RST;
      cfg.first_on_ticks     <= FIRST_ON_RST;
      cfg.first_off_ticks    <= FIRST_OFF_RST;
      cfg.second_pulse_count <= SECOND_PULSE_RST;
      cfg.second_on_ticks    <= SECOND_ON_RST;
      cfg.second_off_ticks   <= SECOND_OFF_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FIRST_PULSE_COUNT:  cfg.first_pulse_count  <= pwdata[CFG_W-1:0];
        REG_FIRST_ON_TICKS:     cfg.first_on_ticks     <= pwdata[CFG_W-1:0];
        REG_FIRST_OFF_TICKS:    cfg.first_off_ticks    <= pwdata[CFG_W-1:0];
        REG_SECOND_PULSE_COUNT: cfg.second_pulse_count <= pwdata[CFG_W-1:0];
        REG_SECOND_ON_TICKS:    cfg.second_on_ticks    <= pwdata[CFG_W-1:0];
        REG_SECOND_OFF_TICKS:   cfg.second_off_ticks   <= pwdata[CFG_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // read mux, unmapped indexes read zero
  always_comb begin
    unique case (reg_idx)
      REG_FIRST_PULSE_COUNT:  prdata = DATA_W'(cfg.first_pulse_count);
      REG_FIRST_ON_TICKS:     prdata = DATA_W'(cfg.first_on_ticks);
      REG_FIRST_OFF_TICKS:    prdata = DATA_W'(cfg.first_off_ticks);
      REG_SECOND_PULSE_COUNT: prdata = DATA_W'(cfg.second_pulse_count);
      REG_SECOND_ON_TICKS:    prdata = DATA_W'(cfg.second_on_ticks);
      REG_SECOND_OFF_TICKS:   prdata = DATA_W'(cfg.second_off_ticks);
      default:                prdata = '0;
    endcase
  end

  // a request is taken whenever the skid register is free
  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // sequencer: state update and result for one tick
  lss_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .step           (accept),
    .enable_request (enable_request),
    .test_mode      (test_mode),
    .result         (seq_res),
    .status         (seq_st)
  );

  // output control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          // skid moves up, a new result refills the skid
          out_valid  <= 1'b1;
          skid_valid <= accept;
        end else begin
          out_valid <= accept;
        end
      end else if (!out_valid) begin
        out_valid <= accept;
      end else if (accept) begin
        // receiver stalled, park the new result
        skid_valid <= 1'b1;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (accept) begin
          skid_res <= seq_res;
        end
      end else if (accept) begin
        out_res <= seq_res;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_res <= seq_res;
      end
    end else if (accept) begin
      skid_res <= seq_res;
    end
  end

  assign gate_on = out_res.gate_on;
  assign ramping = out_res.ramping;

  // skid only ever holds a result behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // a request taken during a stall must land in the skid register
  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !out_ready) |=> skid_valid)
    else $error("request accepted during stall was not parked");

  // test mode outside a ramp forces the gate on with no ramp flag
  a_test_forces_on: assert property (@(posedge clk) disable iff (rst)
    (accept && test_mode && !seq_st.ramp_active) |->
      (seq_res.gate_on && !seq_res.ramping))
    else $error("test mode did not force the gate on");

  // every tick taken while the sequencer is ramping carries the ramp flag
  a_ramp_tracks_state: assert property (@(posedge clk) disable iff (rst)
    (accept && seq_st.ramp_active) |-> seq_res.ramping)
    else $error("ramp tick produced without ramp flag");

endmodule

`default_nettype wire
